// ===== sv/integer_multiply_divide_unit_top_assert.svh =====
// Assertion macros for the multiply/divide unit checker
`ifndef INTEGER_MULTIPLY_DIVIDE_UNIT_TOP_ASSERT_SVH
`define INTEGER_MULTIPLY_DIVIDE_UNIT_TOP_ASSERT_SVH

// assert that an antecedent implies a consequent in the next cycle
`define IMDU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// assert that an expression holds at every clock edge
`define IMDU_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

// ===== sv/imdu_pkg.sv =====
// ----------------------------------------------------------------------------
// imdu_pkg
// Shared types and constants of the multiply/divide unit.
// ----------------------------------------------------------------------------
package imdu_pkg;

    localparam int XLEN = 32;
    localparam int DIV_STAGES = 4;
    localparam int BITS_PER_STAGE = XLEN / DIV_STAGES;
    localparam int LATENCY = DIV_STAGES + 2;

    typedef enum logic [2:0] {
        FUNC_MUL    = 3'd0,
        FUNC_MULH   = 3'd1,
        FUNC_MULHSU = 3'd2,
        FUNC_MULHU  = 3'd3,
        FUNC_DIV    = 3'd4,
        FUNC_DIVU   = 3'd5,
        FUNC_REM    = 3'd6,
        FUNC_REMU   = 3'd7
    } func_t;

    typedef logic [XLEN-1:0] word_t;

    // control carried alongside each item through the divider stages
    typedef struct packed {
        logic  is_div;
        logic  is_rem;
        logic  neg_res;
        logic  div_zero;
        logic  ovf;
        word_t dividend;
    } div_ctl_t;

endpackage

// ===== sv/integer_multiply_divide_unit_top.sv =====
// ----------------------------------------------------------------------------
// integer_multiply_divide_unit_top
// RV32M multiply and divide: eight funct3 operations, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel | signals                          | direction
// input   | valid, ready, func, operand_a/b  | in
// output  | result_valid/ready, result       | out
//
// One item enters per cycle while the output is not stalled.
// Stage 0 takes magnitudes and forms the multiplier partial products;
// four divider stages retire 8 quotient bits each, the product sum rides along;
// the last stage selects and signs the result.
// The whole pipe advances together and holds while the output is stalled.
// Reset clears the valid bits only.
module integer_multiply_divide_unit_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid,
    output logic            ready,
    input  logic [2:0]      func,
    input  imdu_pkg::word_t operand_a,
    input  imdu_pkg::word_t operand_b,
    output logic            result_valid,
    input  logic            result_ready,
    output imdu_pkg::word_t result
);

    localparam int X = imdu_pkg::XLEN;
    localparam int H = X / 2;
    localparam int N = imdu_pkg::DIV_STAGES;

    logic en;

    // stage 0 registers
    logic                  s0_valid_reg;
    imdu_pkg::func_t       s0_func_reg;
    imdu_pkg::word_t       s0_dvd_reg;
    imdu_pkg::word_t       s0_dsr_reg;
    imdu_pkg::div_ctl_t    s0_ctl_reg;
    logic [X-1:0]          s0_pp_reg [4];
    logic [X-1:0]          s0_corr_reg;

    logic                  out_valid_reg;
    imdu_pkg::word_t       out_reg;

    // chain wires
    logic                  c_valid [N+1];
    imdu_pkg::word_t       c_rem   [N+1];
    imdu_pkg::word_t       c_quo   [N+1];
    imdu_pkg::word_t       c_dsr   [N+1];
    imdu_pkg::div_ctl_t    c_ctl   [N+1];
    logic [X-1:0]          c_hi    [N+1];
    logic [2*X-1:0]        c_prod  [N+1];

    imdu_pkg::func_t       f_in;
    logic                  a_neg;
    logic                  b_neg;
    imdu_pkg::word_t       ma;
    imdu_pkg::word_t       mb;
    logic [X-1:0]          corr;
    imdu_pkg::div_ctl_t    ctl_in;
    imdu_pkg::func_t       func_pipe_reg [N];
    imdu_pkg::word_t       r_next;

    assign en    = !out_valid_reg || result_ready;
    assign ready = en;
    assign f_in  = imdu_pkg::func_t'(func);

    always_comb
    begin
        a_neg = 1'b0;
        b_neg = 1'b0;
        corr  = '0;
        unique case (f_in) inside
            imdu_pkg::FUNC_MULH:
            begin
                if (operand_a[X-1]) corr = corr - operand_b;
                if (operand_b[X-1]) corr = corr - operand_a;
            end
            imdu_pkg::FUNC_MULHSU:
            begin
                if (operand_a[X-1]) corr = corr - operand_b;
            end
            imdu_pkg::FUNC_DIV, imdu_pkg::FUNC_REM:
            begin
                a_neg = operand_a[X-1];
                b_neg = operand_b[X-1];
            end
            default: ;
        endcase
        ma = a_neg ? (~operand_a + 1'b1) : operand_a;
        mb = b_neg ? (~operand_b + 1'b1) : operand_b;
        ctl_in.is_div   = f_in[2];
        ctl_in.is_rem   = f_in[1];
        ctl_in.neg_res  = f_in[1] ? a_neg : (a_neg ^ b_neg);
        ctl_in.div_zero = (operand_b == '0);
        ctl_in.ovf      = !f_in[0] && (operand_a == {1'b1, {(X-1){1'b0}}})
                          && (operand_b == '1);
        ctl_in.dividend = operand_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (en)
            s0_valid_reg <= valid;
    end

    // split the unsigned product into four half-width partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_func_reg <= f_in;
            s0_dvd_reg  <= ma;
            s0_dsr_reg  <= mb;
            s0_ctl_reg  <= ctl_in;
            s0_corr_reg <= corr;
            s0_pp_reg[0] <= operand_a[H-1:0] * operand_b[H-1:0];
            s0_pp_reg[1] <= operand_a[H-1:0] * operand_b[X-1:H];
            s0_pp_reg[2] <= operand_a[X-1:H] * operand_b[H-1:0];
            s0_pp_reg[3] <= operand_a[X-1:H] * operand_b[X-1:H];
        end
    end

    assign c_valid[0] = s0_valid_reg;
    assign c_rem[0]   = '0;
    assign c_quo[0]   = s0_dvd_reg;
    assign c_dsr[0]   = s0_dsr_reg;
    assign c_ctl[0]   = s0_ctl_reg;
    assign c_hi[0]    = s0_corr_reg;
    assign c_prod[0]  = {s0_pp_reg[3], s0_pp_reg[0]}
                        + {{H{1'b0}}, s0_pp_reg[1], {H{1'b0}}}
                        + {{H{1'b0}}, s0_pp_reg[2], {H{1'b0}}};

    for (genvar g = 0; g < N; g++)
    begin : g_div
        imdu_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (c_valid[g]),
            .in_rem   (c_rem[g]),
            .in_quo   (c_quo[g]),
            .in_dsr   (c_dsr[g]),
            .in_ctl   (c_ctl[g]),
            .in_hi    (c_hi[g]),
            .in_prod  (c_prod[g]),
            .out_valid(c_valid[g+1]),
            .out_rem  (c_rem[g+1]),
            .out_quo  (c_quo[g+1]),
            .out_dsr  (c_dsr[g+1]),
            .out_ctl  (c_ctl[g+1]),
            .out_hi   (c_hi[g+1]),
            .out_prod (c_prod[g+1])
        );
    end

    // carry the operation code alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func_pipe_reg[0] <= s0_func_reg;
            for (int i = 1; i < N; i++)
                func_pipe_reg[i] <= func_pipe_reg[i-1];
        end
    end

    always_comb
    begin
        imdu_pkg::div_ctl_t ct;
        ct = c_ctl[N];
        unique case (func_pipe_reg[N-1]) inside
            imdu_pkg::FUNC_MUL:
                r_next = c_prod[N][X-1:0];
            imdu_pkg::FUNC_MULH, imdu_pkg::FUNC_MULHSU, imdu_pkg::FUNC_MULHU:
                r_next = c_prod[N][2*X-1:X] + c_hi[N];
            default:
            begin
                if (ct.div_zero)
                    r_next = ct.is_rem ? ct.dividend : '1;
                else if (ct.ovf)
                    r_next = ct.is_rem ? '0 : ct.dividend;
                else if (ct.is_rem)
                    r_next = ct.neg_res ? (~c_rem[N] + 1'b1) : c_rem[N];
                else
                    r_next = ct.neg_res ? (~c_quo[N] + 1'b1) : c_quo[N];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= c_valid[N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= r_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== sv/imdu_div_stage.sv =====
// ----------------------------------------------------------------------------
// imdu_div_stage
// One registered slice of the restoring divider: BITS_PER_STAGE quotient bits.
// ----------------------------------------------------------------------------
module imdu_div_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  imdu_pkg::word_t      in_rem,
    input  imdu_pkg::word_t      in_quo,
    input  imdu_pkg::word_t      in_dsr,
    input  imdu_pkg::div_ctl_t   in_ctl,
    input  logic [imdu_pkg::XLEN-1:0] in_hi,
    input  logic [2*imdu_pkg::XLEN-1:0] in_prod,
    output logic                 out_valid,
    output imdu_pkg::word_t      out_rem,
    output imdu_pkg::word_t      out_quo,
    output imdu_pkg::word_t      out_dsr,
    output imdu_pkg::div_ctl_t   out_ctl,
    output logic [imdu_pkg::XLEN-1:0] out_hi,
    output logic [2*imdu_pkg::XLEN-1:0] out_prod
);

    logic                    valid_reg;
    imdu_pkg::word_t         rem_reg;
    imdu_pkg::word_t         quo_reg;
    imdu_pkg::word_t         dsr_reg;
    imdu_pkg::div_ctl_t      ctl_reg;
    logic [imdu_pkg::XLEN-1:0] hi_reg;
    logic [2*imdu_pkg::XLEN-1:0] prod_reg;
    imdu_pkg::word_t         rem_next;
    imdu_pkg::word_t         quo_next;

    always_comb
    begin
        logic [imdu_pkg::XLEN:0] trial;
        rem_next = in_rem;
        quo_next = in_quo;
        for (int i = 0; i < imdu_pkg::BITS_PER_STAGE; i++)
        begin
            trial = {rem_next, quo_next[imdu_pkg::XLEN-1]} - {1'b0, in_dsr};
            quo_next = {quo_next[imdu_pkg::XLEN-2:0], ~trial[imdu_pkg::XLEN]};
            if (!trial[imdu_pkg::XLEN])
                rem_next = trial[imdu_pkg::XLEN-1:0];
            else
                rem_next = {rem_next[imdu_pkg::XLEN-2:0], in_quo[imdu_pkg::XLEN-1-i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dsr_reg  <= in_dsr;
            ctl_reg  <= in_ctl;
            hi_reg   <= in_hi;
            prod_reg <= in_prod;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_dsr   = dsr_reg;
    assign out_ctl   = ctl_reg;
    assign out_hi    = hi_reg;
    assign out_prod  = prod_reg;

endmodule

// ===== sv/imdu_checker.sv =====
// ----------------------------------------------------------------------------
// imdu_checker
// Port-level checks on the multiply/divide unit.
// ----------------------------------------------------------------------------
`include "integer_multiply_divide_unit_top_assert.svh"

module imdu_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            valid,
    input logic            ready,
    input logic            result_valid,
    input logic            result_ready,
    input imdu_pkg::word_t result
);

    `IMDU_ASSERT_NEXT(a_hold_valid, clk, rst_n, result_valid && !result_ready, result_valid, "result dropped while stalled")
    `IMDU_ASSERT_NEXT(a_hold_data, clk, rst_n, result_valid && !result_ready, $stable(result), "result changed while stalled")
    `IMDU_ASSERT_ALWAYS(a_ready, clk, rst_n, ready == (!result_valid || result_ready), "ready does not follow output stall")
    `IMDU_ASSERT_NEXT(a_stall, clk, rst_n, !ready, result_valid, "result lost while input held off")
    `IMDU_ASSERT_NEXT(a_in_hold, clk, rst_n, valid && !ready, valid, "input transfer withdrawn before acceptance")

endmodule

bind integer_multiply_divide_unit_top imdu_checker u_imdu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (valid),
    .ready       (ready),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

// ===== sim/imdu_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imdu_result_checker
// Watches both channels of the multiply/divide unit, predicts each result
// from the accepted operands and compares it with the result transfer.
// ----------------------------------------------------------------------------
module imdu_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  logic        ready,
    input  logic [2:0]  func,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [31:0] result,
    output int          errors,
    output int          pending
);

    imdu_pkg::word_t expected_results[$];

    function automatic imdu_pkg::word_t compute_result(imdu_pkg::func_t op,
                                                       imdu_pkg::word_t a,
                                                       imdu_pkg::word_t b);
        logic signed [2*imdu_pkg::XLEN+1:0] prod;
        logic [imdu_pkg::XLEN-1:0] ma;
        logic [imdu_pkg::XLEN-1:0] mb;
        logic [imdu_pkg::XLEN-1:0] q;
        logic [imdu_pkg::XLEN-1:0] r;
        logic            a_neg;
        logic            b_neg;
        imdu_pkg::word_t min_neg;
        min_neg = {1'b1, {(imdu_pkg::XLEN-1){1'b0}}};
        a_neg = a[imdu_pkg::XLEN-1];
        b_neg = b[imdu_pkg::XLEN-1];
        ma = a_neg ? -a : a;
        mb = b_neg ? -b : b;
        case (op)
            imdu_pkg::FUNC_MUL:    return a * b;
            imdu_pkg::FUNC_MULH:
            begin
                prod = $signed({{(imdu_pkg::XLEN+2){a_neg}}, a})
                       * $signed({{(imdu_pkg::XLEN+2){b_neg}}, b});
                return prod[2*imdu_pkg::XLEN-1:imdu_pkg::XLEN];
            end
            imdu_pkg::FUNC_MULHSU:
            begin
                prod = $signed({{(imdu_pkg::XLEN+2){a_neg}}, a})
                       * $signed({{(imdu_pkg::XLEN+2){1'b0}}, b});
                return prod[2*imdu_pkg::XLEN-1:imdu_pkg::XLEN];
            end
            imdu_pkg::FUNC_MULHU:
            begin
                prod = $signed({{(imdu_pkg::XLEN+2){1'b0}}, a})
                       * $signed({{(imdu_pkg::XLEN+2){1'b0}}, b});
                return prod[2*imdu_pkg::XLEN-1:imdu_pkg::XLEN];
            end
            imdu_pkg::FUNC_DIV:
            begin
                if (b == '0) return '1;
                if (a == min_neg && b == '1) return a;
                q = ma / mb;
                return (a_neg ^ b_neg) ? -q : q;
            end
            imdu_pkg::FUNC_DIVU:   return (b == '0) ? '1 : a / b;
            imdu_pkg::FUNC_REM:
            begin
                if (b == '0) return a;
                if (a == min_neg && b == '1) return '0;
                r = ma % mb;
                return a_neg ? -r : r;
            end
            default:     return (b == '0) ? a : a % b;
        endcase
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors <= 0;
        end
        else
        begin
            if (valid && ready)
                expected_results.push_back(
                    compute_result(imdu_pkg::func_t'(func), operand_a, operand_b));
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result: unexpected transfer, actual %h", result);
                    errors <= errors + 1;
                end
                else
                begin
                    if (result !== expected_results[0])
                    begin
                        $error("result: expected %h, actual %h", expected_results[0], result);
                        errors <= errors + 1;
                    end
                    void'(expected_results.pop_front());
                end
            end
        end
    end

endmodule

// ===== sim/tb_integer_multiply_divide_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_multiply_divide_unit_top
// Drives directed corner operands and random operations with random gaps
// on both channels; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_integer_multiply_divide_unit_top;

    localparam int RANDOM_OPS = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        ready;
    logic [2:0]  func = imdu_pkg::FUNC_MUL;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [31:0] result;
    int          errors;
    int          pending;
    logic        stall_enable = 1'b0;

    always #5 clk = ~clk;

    integer_multiply_divide_unit_top dut (.*);

    imdu_result_checker checker_i (.*);

    function automatic int gap_length();
        if ($urandom_range(3, 0) == 0) return 0;
        if ($urandom_range(9, 0) == 0) return $urandom_range(30, 8);
        return $urandom_range(3, 0);
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7, 0))
            0:       return 32'h0;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return $urandom_range(16, 0);
            5:       return -$urandom_range(16, 0);
            default: return $urandom;
        endcase
    endfunction

    // valid stays high into the next transfer when there is no gap
    task automatic send_op(imdu_pkg::func_t op, logic [31:0] a, logic [31:0] b);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid     <= 1'b1;
        func      <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!ready) @(posedge clk);
    endtask

    // drop valid and hold off until every result is back
    task automatic drain();
        valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // stall the result side at random, with calm stretches
    initial
    begin
        int hold;
        forever
        begin
            @(posedge clk);
            if (stall_enable && $urandom_range(4, 0) == 0)
            begin
                hold = gap_length();
                if (hold > 0)
                begin
                    result_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
            end
            result_ready <= 1'b1;
        end
    end

    initial
    begin
        logic [31:0] corners[6];
        corners = '{32'h0, 32'h1, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h5555_aaaa};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // every operation on the extremes, divide by zero and signed overflow
        for (int op = 0; op < 8; op++)
        begin
            send_op(imdu_pkg::func_t'(op), 32'h8000_0000, 32'hffff_ffff);
            send_op(imdu_pkg::func_t'(op), 32'hffff_ffff, 32'h0);
            send_op(imdu_pkg::func_t'(op), corners[op % 6], corners[(op + 2) % 6]);
        end
        send_op(imdu_pkg::FUNC_DIV, 32'hffff_fff9, 32'h2);
        drain();
        stall_enable <= 1'b1;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i == RANDOM_OPS / 2)
                drain();
            send_op(imdu_pkg::func_t'($urandom_range(7, 0)), pick_operand(), pick_operand());
        end
        drain();
        repeat (2 * imdu_pkg::LATENCY) @(posedge clk);
        if (errors == 0)
            $display("tb_integer_multiply_divide_unit_top: PASS");
        else
            $display("tb_integer_multiply_divide_unit_top: FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb_integer_multiply_divide_unit_top: FAIL");
        $finish;
    end

endmodule

// ===== integer_multiply_divide_unit_top.f =====
+incdir+sv
sv/imdu_pkg.sv
sv/imdu_div_stage.sv
sv/integer_multiply_divide_unit_top.sv
sv/imdu_checker.sv
sim/imdu_result_checker.sv
sim/tb_integer_multiply_divide_unit_top.sv
